// ===== design/bbpg_pkg.sv =====
package bbpg_pkg;

  // Field widths of the request, the result and the register file.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TicksW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Duty value that means the pin is fully on.
  localparam logic [DutyW-1:0] FullDuty = 8'd255;

  // Pattern phase as presented on the result.
  typedef enum logic [PhaseW-1:0] {
    PhOff  = 2'd0,
    PhOn   = 2'd1,
    PhWait = 2'd2,
    PhDone = 2'd3
  } phase_e;

  // Register word index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    RegOnTicks     = 3'd0,
    RegOffTicks    = 3'd1,
    RegPauseTicks  = 3'd2,
    RegPulseCount  = 3'd3,
    RegDuty        = 3'd4,
    RegRepeat      = 3'd5,
    RegPwmAvail    = 3'd6
  } reg_idx_e;

  // Configuration as seen by the pattern logic.
  typedef struct packed {
    logic [TicksW-1:0] on_ticks;
    logic [TicksW-1:0] off_ticks;
    logic [TicksW-1:0] pause_ticks;
    logic [CountW-1:0] pulse_count;
    logic [DutyW-1:0]  duty;
    logic              repeat_enable;
    logic              pwm_available;
  } cfg_t;

endpackage

// ===== design/bbpg_req_if.sv =====
interface bbpg_req_if import bbpg_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now;

  modport source (output valid, output now, input ready);
  modport sink   (input valid, input now, output ready);

endinterface

// ===== design/bbpg_res_if.sv =====
interface bbpg_res_if import bbpg_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              level_drive;
  logic              pwm_drive;
  logic [DutyW-1:0]  pwm_duty;
  logic [PhaseW-1:0] phase;

  modport source (output valid, output level_drive, output pwm_drive, output pwm_duty,
                  output phase, input ready);
  modport sink   (input valid, input level_drive, input pwm_drive, input pwm_duty,
                  input phase, output ready);

endinterface

// ===== design/bbpg_cfg.sv =====
module bbpg_cfg import bbpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o,
  output logic             reload_o
);

  cfg_t     cfg_q;
  logic     reload_q;
  logic     wr_en;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; a write to a known register raises the reload pulse together with the
  // new value, so the pattern reloads once the new value is visible.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_ticks      <= '0;
      cfg_q.off_ticks     <= '0;
      cfg_q.pause_ticks   <= '0;
      cfg_q.pulse_count   <= '0;
      cfg_q.duty          <= FullDuty;
      cfg_q.repeat_enable <= 1'b0;
      cfg_q.pwm_available <= 1'b0;
      reload_q            <= 1'b0;
    end else begin
      reload_q <= 1'b0;
      if (wr_en) begin
        reload_q <= 1'b1;
        case (idx)
          RegOnTicks:    cfg_q.on_ticks      <= pwdata[TicksW-1:0];
          RegOffTicks:   cfg_q.off_ticks     <= pwdata[TicksW-1:0];
          RegPauseTicks: cfg_q.pause_ticks   <= pwdata[TicksW-1:0];
          RegPulseCount: cfg_q.pulse_count   <= pwdata[CountW-1:0];
          RegDuty:       cfg_q.duty          <= pwdata[DutyW-1:0];
          RegRepeat:     cfg_q.repeat_enable <= pwdata[0];
          RegPwmAvail:   cfg_q.pwm_available <= pwdata[0];
          default:       reload_q            <= 1'b0;
        endcase
      end
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = '0;
    case (idx)
      RegOnTicks:    prdata = DataW'(cfg_q.on_ticks);
      RegOffTicks:   prdata = DataW'(cfg_q.off_ticks);
      RegPauseTicks: prdata = DataW'(cfg_q.pause_ticks);
      RegPulseCount: prdata = DataW'(cfg_q.pulse_count);
      RegDuty:       prdata = DataW'(cfg_q.duty);
      RegRepeat:     prdata = DataW'(cfg_q.repeat_enable);
      RegPwmAvail:   prdata = DataW'(cfg_q.pwm_available);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o    = cfg_q;
  assign reload_o = reload_q;

endmodule

// ===== design/blink_burst_pattern_generator.sv =====
// Throughput: one request per cycle unless a held result waits for res_o.ready; the
// pattern state is updated by one stage of subtract, compare and decrement logic
// between the input and result registers.
// Reset clears the pattern to the off phase with no pulses left, the registers to
// their defaults (duty full on) and both pipeline registers to empty.
module blink_burst_pattern_generator import bbpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  bbpg_req_if.sink         req_i,
  bbpg_res_if.source       res_o
);

  cfg_t cfg;
  logic reload;

  bbpg_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .reload_o (reload)
  );

  // Input register and result register with their valid flags.
  logic              in_valid_q;
  logic [TimeW-1:0]  now_q;
  logic              out_valid_q;
  logic              level_q;
  logic              pwm_q;
  logic [DutyW-1:0]  duty_q;
  logic [PhaseW-1:0] phase_out_q;
  logic              advance;

  // Pattern state.
  phase_e            ph_q, ph_d;
  logic [CountW-1:0] left_q, left_d;
  logic              fin_q, fin_d;
  logic [TimeW-1:0]  start_q, start_d;

  logic [TimeW-1:0]  elapsed;
  logic              level_d;
  logic              pwm_d;
  logic [DutyW-1:0]  duty_d;
  logic [PhaseW-1:0] phase_out_d;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // Next pattern state and result for the request in the input register.
  always_comb begin
    fin_d   = fin_q;
    left_d  = left_q;
    ph_d    = ph_q;
    start_d = start_q;

    // Burst exhausted: either reload and wait for the pause, or finish.
    if (!fin_d && left_d == '0) begin
      ph_d = PhOff;
      if (cfg.repeat_enable && cfg.pulse_count != '0) begin
        left_d  = cfg.pulse_count;
        start_d = now_q;
        ph_d    = PhWait;
      end else begin
        fin_d = 1'b1;
      end
    end

    elapsed = now_q - start_d;

    if (!fin_d && left_d != '0) begin
      case (ph_d)
        PhOff: begin
          // A zero start time starts the pulse at once.
          if (start_d == '0 || elapsed > TimeW'(cfg.off_ticks)) begin
            start_d = now_q;
            ph_d    = PhOn;
          end
        end
        PhOn: begin
          if (elapsed > TimeW'(cfg.on_ticks)) begin
            left_d  = left_d - CountW'(1);
            ph_d    = PhOff;
            start_d = now_q;
          end
        end
        PhWait: begin
          if (elapsed > TimeW'(cfg.pause_ticks)) begin
            start_d = now_q;
            ph_d    = PhOn;
          end
        end
        default: begin
          ph_d = ph_d;
        end
      endcase
    end

    // Pin drive while on: PWM when possible and not full duty, else a steady high.
    level_d = 1'b0;
    pwm_d   = 1'b0;
    duty_d  = '0;
    if (!fin_d && ph_d == PhOn) begin
      if (cfg.pwm_available && cfg.duty < FullDuty) begin
        pwm_d  = 1'b1;
        duty_d = cfg.duty;
      end else begin
        level_d = 1'b1;
      end
    end
    phase_out_d = fin_d ? PhDone : ph_d;
  end

  // Control: valid flags and pattern state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ph_q        <= PhOff;
      left_q      <= '0;
      fin_q       <= 1'b0;
      start_q     <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (reload) begin
        ph_q    <= PhOff;
        left_q  <= cfg.pulse_count;
        fin_q   <= 1'b0;
        start_q <= '0;
      end else if (advance) begin
        ph_q    <= ph_d;
        left_q  <= left_d;
        fin_q   <= fin_d;
        start_q <= start_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      now_q <= req_i.now;
    end
    if (advance) begin
      level_q     <= level_d;
      pwm_q       <= pwm_d;
      duty_q      <= duty_d;
      phase_out_q <= phase_out_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.level_drive = level_q;
  assign res_o.pwm_drive   = pwm_q;
  assign res_o.pwm_duty    = duty_q;
  assign res_o.phase       = phase_out_q;

endmodule
